>>> sv/kpft_pkg.sv
// kpft_pkg: shared types and codes for the keyed pair frequency table
// holds command and status codes, field widths and the entry and result structs
// no dependencies
package kpft_pkg;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 31;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 3;

    localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_IGNORED  = 3'd3;
    localparam logic [STAT_W-1:0] ST_QUERY    = 3'd4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [KEY_W-1:0]   intent;
        logic [KEY_W-1:0]   entity;
        logic [COUNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic               found;
        logic [KEY_W-1:0]   best_entity;
        logic [COUNT_W-1:0] result_count;
    } t_result;

endpackage

>>> sv/keyed_pair_frequency_table_top.sv
// keyed_pair_frequency_table_top: top level of the keyed pair frequency table
// stream ports, output register and the scan sequencer with its entry memory
// depends on kpft_pkg, kpft_ctrl and kpft_mem
//
//  channel  direction  tuser           tdata
//  s_axis   in         [1:0] cmd       [31:0] intent_key, [63:32] entity_key,
//                                      [94:64] load_count, [95] zero
//  m_axis   out        [2:0] status,   [31:0] best_entity, [62:32] result_count,
//                      [3] found       [63] zero
//
// a command reads the used entries one per cycle from the single read port of the
// entry memory, whose read data is registered, then writes back and forms the
// result; on an empty table the scan is skipped. reset empties the table at once;
// no clearing pass runs.
// a new transaction is taken while the previous result still waits in the output
// register; the write-back cycle waits until that register is free.
module keyed_pair_frequency_table_top #(
    parameter int TABLE_ENTRIES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // intent_key, entity_key, load_count, pad
    input  logic [1:0]  s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // best_entity, result_count, pad
    output logic [3:0]  m_axis_tuser    // status, found
);
    import kpft_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    logic    r_out_valid;
    t_result r_out;
    logic    w_res_valid;
    t_result w_res;
    logic    w_res_free;

    assign w_res_free = !r_out_valid || m_axis_tready;

    kpft_ctrl #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_intent    (s_axis_tdata[31:0]),
        .i_entity    (s_axis_tdata[63:32]),
        .i_lcount    (s_axis_tdata[94:64]),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_free  (w_res_free)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_free) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_free && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.result_count, r_out.best_entity};
    assign m_axis_tuser  = {r_out.found, r_out.status};

endmodule

>>> sv/kpft_mem.sv
// kpft_mem: entry store of the keyed pair frequency table
// one write port, one read port with registered read data
// depends on kpft_pkg
module kpft_mem #(
    parameter int DEPTH = 128,
    parameter int IDX_W = 7
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [IDX_W-1:0]     i_waddr,
    input  kpft_pkg::t_entry     i_wdata,
    input  logic [IDX_W-1:0]     i_raddr,
    output kpft_pkg::t_entry     o_rdata
);
    import kpft_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/kpft_ctrl.sv
// kpft_ctrl: scan sequencer of the keyed pair frequency table
// reads the used entries one per cycle, then writes back and forms the result
// depends on kpft_pkg and kpft_mem
module kpft_ctrl #(
    parameter int DEPTH = 128,
    parameter int IDX_W = 7,
    parameter int CNT_W = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [kpft_pkg::CMD_W-1:0]    i_cmd,
    input  logic [kpft_pkg::KEY_W-1:0]    i_intent,
    input  logic [kpft_pkg::KEY_W-1:0]    i_entity,
    input  logic [kpft_pkg::COUNT_W-1:0]  i_lcount,
    output logic                          o_res_valid,
    output kpft_pkg::t_result             o_res,
    input  logic                          i_res_free
);
    import kpft_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]         r_state;
    logic [CNT_W-1:0]   r_used;
    logic [CNT_W-1:0]   r_idx;
    logic               r_cmp_valid;
    logic               r_cmp_last;
    logic [IDX_W-1:0]   r_cmp_idx;

    logic [CMD_W-1:0]   r_cmd;
    logic [KEY_W-1:0]   r_intent;
    logic [KEY_W-1:0]   r_entity;
    logic [COUNT_W-1:0] r_lcount;

    logic               r_hit;
    logic [IDX_W-1:0]   r_hit_idx;
    logic [COUNT_W-1:0] r_hit_count;
    logic               r_found;
    logic [KEY_W-1:0]   r_best_entity;
    logic [COUNT_W-1:0] r_best_count;

    t_entry             w_rdata;
    logic               w_issue;
    logic               w_accept;
    logic               w_fin;

    logic               n_we;
    logic [IDX_W-1:0]   n_waddr;
    t_entry             n_wdata;
    t_result            n_res;
    logic [CNT_W-1:0]   n_used;
    logic [COUNT_W-1:0] n_count;
    logic               n_ignore;

    // nothing is taken while reset is held
    assign o_in_ready = i_rst_n && (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_issue    = (r_state == S_SCAN) && (r_idx != r_used);
    assign w_fin      = (r_state == S_FIN) && i_res_free;

    kpft_mem #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata (n_wdata),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    // final decision once the scan is over
    always_comb begin
        n_we     = 1'b0;
        n_waddr  = r_hit_idx;
        n_used   = r_used;
        n_ignore = ((r_cmd == CMD_RECORD) && (r_entity == '0)) ||
                   ((r_cmd != CMD_RECORD) && (r_cmd != CMD_LOAD) && (r_cmd != CMD_QUERY));
        n_count  = r_lcount;
        n_res    = '{status: ST_IGNORED, found: 1'b0, best_entity: '0, result_count: '0};
        if (r_cmd == CMD_RECORD) begin
            if (r_hit) begin
                n_count = (r_hit_count == COUNT_MAX) ? COUNT_MAX
                                                     : r_hit_count + COUNT_W'(1);
            end else begin
                n_count = COUNT_W'(1);
            end
        end
        n_wdata = '{intent: r_intent, entity: r_entity, count: n_count};
        if (n_ignore) begin
            n_res.status = ST_IGNORED;
        end else if (r_cmd == CMD_QUERY) begin
            n_res = '{status: ST_QUERY, found: r_found, best_entity: r_best_entity,
                      result_count: r_best_count};
        end else if (r_hit) begin
            n_we  = 1'b1;
            n_res = '{status: ST_UPDATED, found: 1'b0, best_entity: r_entity,
                      result_count: n_count};
        end else if (r_used >= CNT_W'(DEPTH)) begin
            n_res = '{status: ST_FULL, found: 1'b0, best_entity: r_entity,
                      result_count: '0};
        end else begin
            n_we    = 1'b1;
            n_waddr = r_used[IDX_W-1:0];
            n_used  = r_used + CNT_W'(1);
            n_res   = '{status: ST_INSERTED, found: 1'b0, best_entity: r_entity,
                        result_count: n_count};
        end
        if (!w_fin) begin
            n_we   = 1'b0;
            n_used = r_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_cmp_valid <= 1'b0;
        end else begin
            r_used      <= n_used;
            r_cmp_valid <= w_issue;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= (r_used == '0) ? S_FIN : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_cmp_valid && r_cmp_last) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (i_res_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // scan datapath: issue one read a cycle, compare the data in the next cycle
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd         <= i_cmd;
            r_intent      <= i_intent;
            r_entity      <= i_entity;
            r_lcount      <= i_lcount;
            r_idx         <= '0;
            r_hit         <= 1'b0;
            r_found       <= 1'b0;
            r_best_entity <= '0;
            r_best_count  <= '0;
        end else begin
            if (w_issue) begin
                r_idx      <= r_idx + CNT_W'(1);
                r_cmp_idx  <= r_idx[IDX_W-1:0];
                r_cmp_last <= ((r_idx + CNT_W'(1)) == r_used);
            end
            if (r_cmp_valid) begin
                if (!r_hit && (w_rdata.intent == r_intent)
                        && (w_rdata.entity == r_entity)) begin
                    r_hit       <= 1'b1;
                    r_hit_idx   <= r_cmp_idx;
                    r_hit_count <= w_rdata.count;
                end
                if ((w_rdata.intent == r_intent) && (w_rdata.count > r_best_count)) begin
                    r_found       <= 1'b1;
                    r_best_entity <= w_rdata.entity;
                    r_best_count  <= w_rdata.count;
                end
            end
        end
    end

    assign o_res_valid = w_fin;
    assign o_res       = n_res;

endmodule
